@@ sv/qau_pkg.sv @@
package qau_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_MUL  = 2'd0;
  localparam op_t OP_INV  = 2'd1;
  localparam op_t OP_NORM = 2'd2;
  localparam op_t OP_CONJ = 2'd3;

  localparam int FLOOR_W = 16;

  // hamilton product terms: a index, b index, subtract flag
  localparam logic [1:0] HAM_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic [1:0] HAM_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic HAM_SUB [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

@@ sv/qau_chan_if.sv @@
interface qau_in_if #(parameter int W = 16) ();
  logic                 valid;
  logic                 ready;
  qau_pkg::op_t         operation;
  logic signed [W-1:0]  a_w;
  logic signed [W-1:0]  a_x;
  logic signed [W-1:0]  a_y;
  logic signed [W-1:0]  a_z;
  logic signed [W-1:0]  b_w;
  logic signed [W-1:0]  b_x;
  logic signed [W-1:0]  b_y;
  logic signed [W-1:0]  b_z;
  modport source (output valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

interface qau_out_if #(parameter int W = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [W-1:0]  r_w;
  logic signed [W-1:0]  r_x;
  logic signed [W-1:0]  r_y;
  logic signed [W-1:0]  r_z;
  logic                 near_zero;
  logic                 saturated;
  modport source (output valid, r_w, r_x, r_y, r_z, near_zero, saturated, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, near_zero, saturated, output ready);
endinterface

interface qau_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [qau_pkg::FLOOR_W-1:0]   norm_floor;
  modport source (output valid, norm_floor, input ready);
  modport sink (input valid, norm_floor, output ready);
endinterface

@@ sv/quaternion_arith_unit_top.sv @@
// fixed-point quaternion unit: one beat in, one beat out, fully pipelined so a new
// beat can enter every cycle while the pipe is not stalled. the root has NW bits, where
// NW = max(2*COMPONENT_WIDTH+1-FRACTION_BITS, COMPONENT_WIDTH) + 1. the depth comes
// from the bit-per-stage square root (one stage per root bit) followed by four
// parallel restoring dividers (one stage per quotient bit). front end: hamilton
// products, sum and round, squares, sum of squares. the whole pipe stalls together
// when the output beat is held, except that an empty last stage lets the pipe keep
// filling behind a waiting result.
// norm_floor is written through cfg_ch, always ready; write it only while idle.
module quaternion_arith_unit_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  qau_in_if.sink     in_ch,
  qau_out_if.source  out_ch,
  qau_cfg_if.sink    cfg_ch
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int PW   = 2 * W;                  // one product
  localparam int AW   = 2 * W + 1;              // magnitude of a product sum
  localparam int RQW  = AW - F;                 // rounded product magnitude
  localparam int QMW  = (RQW > W) ? RQW : W;    // source magnitude
  localparam int SQW  = 2 * QMW;
  localparam int SSW  = 2 * QMW + 2;            // sum of squares
  localparam int NW   = QMW + 1;                // root bits
  localparam int RW   = SSW;                    // divisor and remainder
  localparam int QB   = W;                      // quotient bits
  localparam int N1   = W + 2 * F;
  localparam int N2   = QMW + F;
  localparam int N12  = (N1 > N2) ? N1 : N2;
  localparam int NUMW = ((N12 > SSW) ? N12 : SSW) + 1;
  localparam int MW   = (QMW > F + 1) ? QMW : F + 1;
  localparam int CW   = (NW > qau_pkg::FLOOR_W) ? NW : qau_pkg::FLOOR_W;

  // ---------------- configuration ----------------
  logic [qau_pkg::FLOOR_W-1:0] floor_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
    end else if (cfg_ch.valid) begin
      floor_r <= cfg_ch.norm_floor;
    end
  end

  // ---------------- flow control ----------------
  logic adv;
  logic out_load;
  logic dv_v_r [QB+1];
  logic out_valid_r;

  assign out_load    = !out_valid_r || out_ch.ready;
  // a bubble in the last stage can be squeezed out while the result waits
  assign adv         = out_load || !dv_v_r[QB];
  assign in_ch.ready = adv;

  logic signed [W-1:0] a_in [4];
  logic signed [W-1:0] b_in [4];

  assign a_in[0] = in_ch.a_w;
  assign a_in[1] = in_ch.a_x;
  assign a_in[2] = in_ch.a_y;
  assign a_in[3] = in_ch.a_z;
  assign b_in[0] = in_ch.b_w;
  assign b_in[1] = in_ch.b_x;
  assign b_in[2] = in_ch.b_y;
  assign b_in[3] = in_ch.b_z;

  // ---------------- stage 1: the sixteen hamilton products ----------------
  logic                 s1_v_r;
  qau_pkg::op_t         s1_op_r;
  logic signed [W-1:0]  s1_a_r [4];
  logic signed [PW-1:0] s1_p_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r <= in_ch.operation;
      for (int i = 0; i < 4; i++) begin
        s1_a_r[i] <= a_in[i];
        for (int k = 0; k < 4; k++) begin
          s1_p_r[i][k] <= a_in[qau_pkg::HAM_A[i][k]] * b_in[qau_pkg::HAM_B[i][k]];
        end
      end
    end
  end

  // ---------------- stage 2: sum, round half away from zero, pick source ----------------
  logic [QMW-1:0] s2_m_nxt [4];
  logic           s2_n_nxt [4];

  always_comb begin
    logic signed [AW:0] acc;
    logic signed [AW:0] term;
    logic [AW-1:0]      mag;
    logic [AW-1:0]      rnd;
    logic [W-1:0]       am;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        term = {{(AW + 1 - PW){s1_p_r[i][k][PW-1]}}, s1_p_r[i][k]};
        if (qau_pkg::HAM_SUB[i][k]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      mag = acc[AW] ? AW'(-acc) : AW'(acc);
      rnd = (mag + (AW'(1) << (F - 1))) >> F;
      am  = s1_a_r[i][W-1] ? W'(-s1_a_r[i]) : W'(s1_a_r[i]);
      if (s1_op_r == qau_pkg::OP_MUL) begin
        s2_m_nxt[i] = QMW'(rnd[RQW-1:0]);
        s2_n_nxt[i] = acc[AW];
      end else begin
        s2_m_nxt[i] = QMW'(am);
        s2_n_nxt[i] = s1_a_r[i][W-1];
      end
    end
  end

  logic           s2_v_r;
  qau_pkg::op_t   s2_op_r;
  logic [QMW-1:0] s2_m_r [4];
  logic           s2_n_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r <= s1_op_r;
      s2_m_r  <= s2_m_nxt;
      s2_n_r  <= s2_n_nxt;
    end
  end

  // ---------------- stage 3: squares ----------------
  logic           s3_v_r;
  qau_pkg::op_t   s3_op_r;
  logic [QMW-1:0] s3_m_r [4];
  logic           s3_n_r [4];
  logic [SQW-1:0] s3_sq_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op_r <= s2_op_r;
      s3_m_r  <= s2_m_r;
      s3_n_r  <= s2_n_r;
      for (int i = 0; i < 4; i++) begin
        s3_sq_r[i] <= SQW'(s2_m_r[i]) * SQW'(s2_m_r[i]);
      end
    end
  end

  // ---------------- stage 4 and root stages ----------------
  // index 0 holds the sum of squares, index j has resolved j root bits
  logic           sr_v_r   [NW+1];
  qau_pkg::op_t   sr_op_r  [NW+1];
  logic [QMW-1:0] sr_m_r   [NW+1][4];
  logic           sr_n_r   [NW+1][4];
  logic [SSW-1:0] sr_ss_r  [NW+1];
  logic [NW+1:0]  sr_rem_r [NW+1];
  logic [NW-1:0]  sr_res_r [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v_r[0] <= 1'b0;
    end else if (adv) begin
      sr_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_op_r[0]  <= s3_op_r;
      sr_m_r[0]   <= s3_m_r;
      sr_n_r[0]   <= s3_n_r;
      sr_ss_r[0]  <= SSW'(s3_sq_r[0]) + SSW'(s3_sq_r[1]) + SSW'(s3_sq_r[2])
                   + SSW'(s3_sq_r[3]);
      sr_rem_r[0] <= '0;
      sr_res_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= NW; j++) begin : g_root
    localparam int P = NW - j;
    logic [NW+1:0] rem2;
    logic [NW+1:0] trial;
    logic          take;

    assign rem2  = {sr_rem_r[j-1][NW-1:0], sr_ss_r[j-1][2*P+1:2*P]};
    assign trial = {sr_res_r[j-1], 2'b01};
    assign take  = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[j] <= 1'b0;
      end else if (adv) begin
        sr_v_r[j] <= sr_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_op_r[j]  <= sr_op_r[j-1];
        sr_m_r[j]   <= sr_m_r[j-1];
        sr_n_r[j]   <= sr_n_r[j-1];
        sr_ss_r[j]  <= sr_ss_r[j-1];
        sr_rem_r[j] <= take ? (rem2 - trial) : rem2;
        sr_res_r[j] <= {sr_res_r[j-1][NW-2:0], take};
      end
    end
  end

  // ---------------- divider setup ----------------
  // normalize and multiply divide by the root, inverse by the sum of squares;
  // numerator carries the rounding half of the divisor
  logic               dp_near;
  logic [RW-1:0]      dp_d;
  logic               dp_ovf [4];
  logic [RW-1:0]      dp_rem [4];
  logic [QB-1:0]      dp_low [4];

  always_comb begin
    logic [NUMW-1:0] num;
    logic [NUMW-1:0] hi;
    dp_near = (sr_op_r[NW] != qau_pkg::OP_CONJ)
           && (CW'(sr_res_r[NW]) <= CW'(floor_r));
    dp_d    = (sr_op_r[NW] == qau_pkg::OP_INV) ? sr_ss_r[NW] : RW'(sr_res_r[NW]);
    for (int i = 0; i < 4; i++) begin
      if (sr_op_r[NW] == qau_pkg::OP_INV) begin
        num = (NUMW'(sr_m_r[NW][i]) << (2 * F)) + NUMW'(dp_d >> 1);
      end else begin
        num = (NUMW'(sr_m_r[NW][i]) << F) + NUMW'(dp_d >> 1);
      end
      hi        = num >> QB;
      dp_ovf[i] = hi >= NUMW'(dp_d);
      dp_rem[i] = RW'(hi);
      dp_low[i] = num[QB-1:0];
    end
  end

  // ---------------- divider stages ----------------
  qau_pkg::op_t   dv_op_r   [QB+1];
  logic [QMW-1:0] dv_m_r    [QB+1][4];
  logic           dv_n_r    [QB+1][4];
  logic           dv_near_r [QB+1];
  logic [RW-1:0]  dv_d_r    [QB+1];
  logic           dv_ovf_r  [QB+1][4];
  logic [RW-1:0]  dv_rem_r  [QB+1][4];
  logic [QB-1:0]  dv_low_r  [QB+1][4];
  logic [QB-1:0]  dv_q_r    [QB+1][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sr_v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_op_r[0]   <= sr_op_r[NW];
      dv_m_r[0]    <= sr_m_r[NW];
      dv_n_r[0]    <= sr_n_r[NW];
      dv_near_r[0] <= dp_near;
      dv_d_r[0]    <= dp_d;
      dv_ovf_r[0]  <= dp_ovf;
      dv_rem_r[0]  <= dp_rem;
      dv_low_r[0]  <= dp_low;
      for (int i = 0; i < 4; i++) begin
        dv_q_r[0][i] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [RW-1:0] rem_nxt [4];
    logic          qbit    [4];

    always_comb begin
      logic [RW:0] r2;
      for (int i = 0; i < 4; i++) begin
        r2 = {dv_rem_r[j-1][i], dv_low_r[j-1][i][QB-j]};
        qbit[i] = r2 >= {1'b0, dv_d_r[j-1]};
        rem_nxt[i] = qbit[i] ? RW'(r2 - {1'b0, dv_d_r[j-1]}) : RW'(r2);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_op_r[j]   <= dv_op_r[j-1];
        dv_m_r[j]    <= dv_m_r[j-1];
        dv_n_r[j]    <= dv_n_r[j-1];
        dv_near_r[j] <= dv_near_r[j-1];
        dv_d_r[j]    <= dv_d_r[j-1];
        dv_ovf_r[j]  <= dv_ovf_r[j-1];
        dv_rem_r[j]  <= rem_nxt;
        dv_low_r[j]  <= dv_low_r[j-1];
        for (int i = 0; i < 4; i++) begin
          dv_q_r[j][i] <= {dv_q_r[j-1][i][QB-2:0], qbit[i]};
        end
      end
    end
  end

  // ---------------- output: select, saturate, sign ----------------
  // returns {clipped, word}
  function automatic logic [W:0] pack_word(input logic neg, input logic [MW-1:0] mag,
                                           input logic ovf);
    logic [MW-1:0] lim;
    logic [MW-1:0] mm;
    logic          clip;
    lim  = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
    clip = ovf || (mag > lim);
    mm   = clip ? lim : mag;
    pack_word = {clip, neg ? W'(MW'(0) - mm) : W'(mm)};
  endfunction

  logic [W-1:0] out_w_nxt [4];
  logic         sat_nxt;

  always_comb begin
    qau_pkg::op_t  op;
    logic          cn;
    logic [MW-1:0] mag;
    logic          ovf;
    logic [W:0]    pw;
    op      = dv_op_r[QB];
    sat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cn  = dv_n_r[QB][i];
      if (i != 0 && (op == qau_pkg::OP_INV || op == qau_pkg::OP_CONJ)) begin
        cn = !cn;
      end
      ovf = 1'b0;
      if (op == qau_pkg::OP_CONJ) begin
        mag = MW'(dv_m_r[QB][i]);
      end else if (dv_near_r[QB] && op == qau_pkg::OP_INV) begin
        // identity
        cn  = 1'b0;
        mag = (i == 0) ? (MW'(1) << F) : '0;
      end else if (dv_near_r[QB]) begin
        mag = MW'(dv_m_r[QB][i]);
      end else begin
        mag = MW'(dv_q_r[QB][i]);
        ovf = dv_ovf_r[QB][i];
      end
      pw           = pack_word(cn, mag, ovf);
      out_w_nxt[i] = pw[W-1:0];
      sat_nxt      = sat_nxt | pw[W];
    end
  end

  logic [W-1:0] out_w_r [4];
  logic         near_r;
  logic         sat_r;
  qau_pkg::op_t out_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_w_r  <= out_w_nxt;
      near_r   <= dv_near_r[QB];
      sat_r    <= sat_nxt;
      out_op_r <= dv_op_r[QB];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.r_w       = out_w_r[0];
  assign out_ch.r_x       = out_w_r[1];
  assign out_ch.r_y       = out_w_r[2];
  assign out_ch.r_z       = out_w_r[3];
  assign out_ch.near_zero = near_r;
  assign out_ch.saturated = sat_r;

`ifndef NO_ASSERTIONS
  // conjugate never tests the norm
  a_conj_not_near: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_op_r == qau_pkg::OP_CONJ) |-> !near_r)
    else $error("conjugate beat flagged near zero");

  // a near-zero inverse is the identity, vector part zero
  a_inv_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_op_r == qau_pkg::OP_INV && near_r)
      |-> (out_w_r[1] == '0 && out_w_r[2] == '0 && out_w_r[3] == '0))
    else $error("near-zero inverse is not the identity");

  // a held result beat stays put
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_w_r[0])
                                         && $stable(sat_r)))
    else $error("waiting result beat changed");
`endif

endmodule
